@@ rtl/core/sctsu_pkg.sv @@
// shared types and constants for the sparse chunked tile store
`default_nettype none
package sctsu_pkg;
	localparam int HASH_SLOTS_DEF  = 64;
	localparam int POOL_CHUNKS_DEF = 64;
	localparam int CHUNK_SHIFT_DEF = 4;
	localparam int Z_W             = 24;
	localparam int WORD_W          = 32;

	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef struct packed {
		logic              func;
		logic [31:0]       tile_x;
		logic [31:0]       tile_y;
		logic [Z_W-1:0]    tile_z;
		logic [WORD_W-1:0] write_value;
	} sctsu_cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_value;
		logic              chunk_present;
		logic              pool_full;
	} sctsu_rsp_t;
endpackage
`default_nettype wire

@@ rtl/core/sparse_chunked_tile_store_unit.sv @@
// sparse chunked tile store: chained hash of chunk keys over three rams
// flow: hash, head check, then a compare for each chain entry visited (key ram read)
// a read hit then passes the tile ram read (S_TRD, S_TOUT); a miss passes S_MISS
// a write that creates a chunk then fills all 2^(2*CHUNK_SHIFT) tile words of it, one ram word at a time
// one transaction at a time; done pulses one cycle with the result, busy drops the same cycle
// reset clears valid bits and pool count at once; keys, links and tiles need no clearing
`default_nettype none
module sparse_chunked_tile_store_unit #(
	parameter int HASH_SLOTS  = sctsu_pkg::HASH_SLOTS_DEF,
	parameter int POOL_CHUNKS = sctsu_pkg::POOL_CHUNKS_DEF,
	parameter int CHUNK_SHIFT = sctsu_pkg::CHUNK_SHIFT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire sctsu_pkg::sctsu_cmd_t cmd,
	output logic                       busy,
	output logic                       done,
	output sctsu_pkg::sctsu_rsp_t      rsp
);
	import sctsu_pkg::*;

	localparam int ENTRIES = HASH_SLOTS + POOL_CHUNKS;
	localparam int E_W     = $clog2(ENTRIES);
	localparam int SLOT_W  = (HASH_SLOTS > 1) ? $clog2(HASH_SLOTS) : 1;
	localparam int LINK_W  = $clog2(POOL_CHUNKS + 1);
	localparam int KXY_W   = 32 - CHUNK_SHIFT;
	localparam int KEY_W   = 2 * KXY_W + Z_W;
	localparam int LOC_W   = 2 * CHUNK_SHIFT;
	localparam int TILES   = 1 << LOC_W;
	localparam int T_W     = E_W + LOC_W;
	localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'(HASH_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_HASH, S_LOOK, S_CMP, S_MISS, S_FILL, S_TRD, S_TOUT
	} state_t;

	state_t              state_q;
	logic                func_q;
	logic [KXY_W-1:0]    cx_q, cy_q;
	logic [Z_W-1:0]      cz_q;
	logic [LOC_W-1:0]    loc_q;
	logic [WORD_W-1:0]   wv_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [E_W-1:0]      e_q, tgt_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [LINK_W-1:0]   pool_q;
	logic [LOC_W-1:0]    fill_q;

	logic [31:0]         hash;
	logic [SLOT_W-1:0]   slot;
	logic [KEY_W-1:0]    key_rd;
	logic [LINK_W-1:0]   link_rd;
	logic [WORD_W-1:0]   tile_rd;
	logic [E_W-1:0]      e_next;
	logic                match, chain_end;

	logic                key_we, link_we, tile_we;
	logic [E_W-1:0]      key_ra, link_wa;
	logic [LINK_W-1:0]   link_wd;
	logic [T_W-1:0]      tile_wa, tile_ra;
	logic [WORD_W-1:0]   tile_wd;

	assign hash = (32'(cx_q) * 32'd19) + (32'(cy_q) * 32'd7) + (32'(cz_q) * 32'd3);
	assign slot = hash[SLOT_W-1:0] & SLOT_MASK;

	assign match     = valid_q[e_q] && (key_rd == {cx_q, cy_q, cz_q});
	assign chain_end = (link_rd == '0) || (32'(link_rd) > 32'(POOL_CHUNKS));
	assign e_next    = E_W'(HASH_SLOTS) + E_W'(link_rd) - E_W'(1);
	assign key_ra    = (state_q == S_CMP) ? e_next : e_q;
	assign tile_ra   = {e_q, loc_q};

	always_comb begin
		key_we  = 1'b0;
		link_we = 1'b0;
		link_wa = tgt_q;
		link_wd = '0;
		tile_we = 1'b0;
		tile_wa = {tgt_q, fill_q};
		tile_wd = (fill_q == loc_q) ? wv_q : WORD_W'(1);
		unique case (state_q)
			S_CMP: begin
				if (match && func_q == FUNC_WRITE) begin
					tile_we = 1'b1;
					tile_wa = {e_q, loc_q};
					tile_wd = wv_q;
				end
			end
			S_MISS: begin
				// append: link the chain tail to the new pool entry
				if (func_q == FUNC_WRITE && valid_q[slot_q] &&
					32'(pool_q) < 32'(POOL_CHUNKS)) begin
					link_we = 1'b1;
					link_wa = e_q;
					link_wd = pool_q + LINK_W'(1);
				end
			end
			S_FILL: begin
				tile_we = 1'b1;
				key_we  = (fill_q == '0);
				link_we = (fill_q == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			pool_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q  <= cmd.func;
						cx_q    <= cmd.tile_x[31:CHUNK_SHIFT];
						cy_q    <= cmd.tile_y[31:CHUNK_SHIFT];
						cz_q    <= cmd.tile_z;
						loc_q   <= {cmd.tile_y[CHUNK_SHIFT-1:0], cmd.tile_x[CHUNK_SHIFT-1:0]};
						wv_q    <= cmd.write_value;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					slot_q  <= slot;
					e_q     <= E_W'(slot);
					state_q <= S_LOOK;
				end
				S_LOOK: begin
					state_q <= valid_q[e_q] ? S_CMP : S_MISS;
				end
				S_CMP: begin
					priority if (match) begin
						if (func_q == FUNC_WRITE) begin
							rsp     <= '{read_value: '0, chunk_present: 1'b1, pool_full: 1'b0};
							done    <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_TRD;
						end
					end else if (chain_end) begin
						state_q <= S_MISS;
					end else begin
						e_q <= e_next;
					end
				end
				S_MISS: begin
					fill_q <= '0;
					priority if (func_q == FUNC_READ) begin
						rsp     <= '{read_value: '0, chunk_present: 1'b0, pool_full: 1'b0};
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else if (!valid_q[slot_q]) begin
						tgt_q            <= E_W'(slot_q);
						valid_q[slot_q]  <= 1'b1;
						state_q          <= S_FILL;
					end else if (32'(pool_q) < 32'(POOL_CHUNKS)) begin
						tgt_q   <= E_W'(HASH_SLOTS) + E_W'(pool_q);
						valid_q[E_W'(HASH_SLOTS) + E_W'(pool_q)] <= 1'b1;
						pool_q  <= pool_q + LINK_W'(1);
						state_q <= S_FILL;
					end else begin
						rsp     <= '{read_value: '0, chunk_present: 1'b0, pool_full: 1'b1};
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FILL: begin
					fill_q <= fill_q + LOC_W'(1);
					if (fill_q == LOC_W'(TILES - 1)) begin
						rsp     <= '{read_value: '0, chunk_present: 1'b1, pool_full: 1'b0};
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_TRD: begin
					state_q <= S_TOUT;
				end
				S_TOUT: begin
					rsp     <= '{read_value: tile_rd, chunk_present: 1'b1, pool_full: 1'b0};
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	sctsu_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(tgt_q), .wdata({cx_q, cy_q, cz_q}),
		.raddr(key_ra), .rdata(key_rd)
	);

	sctsu_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
		.raddr(key_ra), .rdata(link_rd)
	);

	sctsu_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES * TILES)) u_tile_ram (
		.clk(clk), .we(tile_we), .waddr(tile_wa), .wdata(tile_wd),
		.raddr(tile_ra), .rdata(tile_rd)
	);
endmodule
`default_nettype wire

@@ rtl/core/sctsu_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none
module sctsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/sctsu_checker.sv @@
// port-level checks for the sparse chunked tile store, bound to the top level
`default_nettype none
module sctsu_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire sctsu_pkg::sctsu_rsp_t rsp
);
	import sctsu_pkg::*;

	// an accepted transaction always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept without busy");

	// busy ends only with a result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy dropped without result");

	// done is never asserted twice in a row
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("repeated result");

	// a dropped write reports no chunk and no data
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.pool_full |-> !rsp.chunk_present && rsp.read_value == '0)
		else $error("bad pool full result");
endmodule

bind sparse_chunked_tile_store_unit sctsu_checker u_sctsu_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
`default_nettype wire
